### rtl/sptr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sptr_pkg: shared types and constants of the sandpile tile relaxer
// op codes, register indexes, select codes, the command and status groups
// between controller and datapath, and the saturating adder
// ----------------------------------------------------------------------------
package sptr_pkg;

  localparam int DIM_W     = 9;   // holds a tile dimension up to 256
  localparam int CNT_W     = 11;  // up to four sides of 256 spill entries
  localparam int REG_IDX_W = 3;
  localparam int PEND_W    = 9;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_RELAX = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_SPILL = 3'd4;

  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_LEFT   = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_TILE_COLS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TILE_ROWS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd5;

  // address selects for cell reads and queued-flag writes
  localparam logic [1:0] ADDR_ITEM = 2'd0;
  localparam logic [1:0] ADDR_SCAN = 2'd1;
  localparam logic [1:0] ADDR_CUR  = 2'd2;
  localparam logic [1:0] ADDR_TGT  = 2'd3;

  // cell write kinds; each implies its address
  localparam logic [1:0] WR_SET  = 2'd0;  // item address, item value
  localparam logic [1:0] WR_ADD  = 2'd1;  // item address, cell plus value
  localparam logic [1:0] WR_REM  = 2'd2;  // toppling cell keeps remainder
  localparam logic [1:0] WR_GIVE = 2'd3;  // neighbour cell plus grains

  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_CELL  = 2'd1;
  localparam logic [1:0] RES_SPILL = 2'd2;

  localparam logic [1:0] KIND_LOST  = 2'd0;
  localparam logic [1:0] KIND_CELL  = 2'd1;
  localparam logic [1:0] KIND_SPILL = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       cell_rd;
    logic [1:0] cell_rsel;
    logic       cell_wr;
    logic [1:0] cell_wsel;
    logic       spill_rd;
    logic       spill_rtgt;
    logic       spill_wr;
    logic       relax_init;
    logic       scan_step;
    logic       fifo_push;
    logic       push_tgt;
    logic       fifo_pop;
    logic       cur_load;
    logic       topple_load;
    logic       nb_clear;
    logic       nb_step;
    logic       tgt_load;
    logic       q_rd;
    logic       q_wr;
    logic [1:0] q_wsel;
    logic       res_load;
    logic [1:0] res_sel;
    logic       pend_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       in_tile;
    logic       hot;
    logic       scan_last;
    logic       fifo_empty;
    logic [1:0] kind;
    logic       nb_last;
    logic       give_hot;
    logic       queued;
  } stat_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage
`default_nettype wire

### rtl/sptr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sptr_ctrl: sequencer of the sandpile tile relaxer
// walks each op through its memory accesses and owns the handshakes
// ----------------------------------------------------------------------------
module sptr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire sptr_pkg::stat_t stat,
  output sptr_pkg::cmd_t     cmd
);
  import sptr_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_CELL  = 5'd2;
  localparam logic [4:0] S_SPILL = 5'd3;
  localparam logic [4:0] S_SCAN  = 5'd4;
  localparam logic [4:0] S_SCANC = 5'd5;
  localparam logic [4:0] S_POP   = 5'd6;
  localparam logic [4:0] S_LOAD  = 5'd7;
  localparam logic [4:0] S_FETCH = 5'd8;
  localparam logic [4:0] S_TOP   = 5'd9;
  localparam logic [4:0] S_NB    = 5'd10;
  localparam logic [4:0] S_NBRC  = 5'd11;
  localparam logic [4:0] S_NBC   = 5'd12;
  localparam logic [4:0] S_NBQ   = 5'd13;
  localparam logic [4:0] S_NBRS  = 5'd14;
  localparam logic [4:0] S_NBS   = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       in_acc;
  logic       out_free;
  logic [4:0] adv_state;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  // after a neighbour: next direction, or back to the work list
  assign adv_state = stat.nb_last ? S_POP : S_NB;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_ZERO;
        state_next   = S_DONE;
        unique case (stat.op)
          OP_WRITE: begin
            cmd.cell_wr   = stat.in_tile;
            cmd.cell_wsel = WR_SET;
          end
          OP_ADD, OP_READ: begin
            if (stat.in_tile) begin
              cmd.cell_rd   = 1'b1;
              cmd.cell_rsel = ADDR_ITEM;
              state_next    = S_CELL;
            end
          end
          OP_SPILL: begin
            cmd.spill_rd = 1'b1;
            state_next   = S_SPILL;
          end
          OP_RELAX: begin
            cmd.relax_init = 1'b1;
            state_next     = S_SCAN;
          end
          default: begin
          end
        endcase
      end
      S_CELL: begin
        if (stat.op == OP_ADD) begin
          cmd.cell_wr   = 1'b1;
          cmd.cell_wsel = WR_ADD;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_CELL;
        end
        state_next = S_DONE;
      end
      S_SPILL: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_SPILL;
        state_next   = S_DONE;
      end
      S_SCAN: begin
        cmd.cell_rd   = 1'b1;
        cmd.cell_rsel = ADDR_SCAN;
        state_next    = S_SCANC;
      end
      S_SCANC: begin
        cmd.q_wr      = 1'b1;
        cmd.q_wsel    = ADDR_SCAN;
        cmd.fifo_push = stat.hot;
        cmd.scan_step = 1'b1;
        state_next    = stat.scan_last ? S_POP : S_SCAN;
      end
      S_POP: begin
        if (stat.fifo_empty) begin
          state_next = S_FIN;
        end else begin
          cmd.fifo_pop = 1'b1;
          state_next   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.cur_load = 1'b1;
        state_next   = S_FETCH;
      end
      S_FETCH: begin
        cmd.cell_rd   = 1'b1;
        cmd.cell_rsel = ADDR_CUR;
        cmd.q_wr      = 1'b1;
        cmd.q_wsel    = ADDR_CUR;
        state_next    = S_TOP;
      end
      S_TOP: begin
        if (stat.hot) begin
          cmd.cell_wr     = 1'b1;
          cmd.cell_wsel   = WR_REM;
          cmd.topple_load = 1'b1;
          cmd.nb_clear    = 1'b1;
          state_next      = S_NB;
        end else begin
          state_next = S_POP;
        end
      end
      S_NB: begin
        cmd.tgt_load = 1'b1;
        unique case (stat.kind)
          KIND_CELL:  state_next = S_NBRC;
          KIND_SPILL: state_next = S_NBRS;
          default: begin
            cmd.nb_step = 1'b1;
            state_next  = adv_state;
          end
        endcase
      end
      S_NBRC: begin
        cmd.cell_rd   = 1'b1;
        cmd.cell_rsel = ADDR_TGT;
        state_next    = S_NBC;
      end
      S_NBC: begin
        cmd.cell_wr   = 1'b1;
        cmd.cell_wsel = WR_GIVE;
        if (stat.give_hot) begin
          cmd.q_rd   = 1'b1;
          state_next = S_NBQ;
        end else begin
          cmd.nb_step = 1'b1;
          state_next  = adv_state;
        end
      end
      S_NBQ: begin
        if (!stat.queued) begin
          cmd.fifo_push = 1'b1;
          cmd.push_tgt  = 1'b1;
          cmd.q_wr      = 1'b1;
          cmd.q_wsel    = ADDR_TGT;
        end
        cmd.nb_step = 1'b1;
        state_next  = adv_state;
      end
      S_NBRS: begin
        cmd.spill_rd   = 1'b1;
        cmd.spill_rtgt = 1'b1;
        state_next     = S_NBS;
      end
      S_NBS: begin
        cmd.spill_wr = 1'b1;
        cmd.nb_step  = 1'b1;
        state_next   = adv_state;
      end
      S_FIN: begin
        cmd.pend_load = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/sptr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sptr_dp: datapath of the sandpile tile relaxer
// config registers, cell store, work list, queued flags, spill counters
// ----------------------------------------------------------------------------
module sptr_dp #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [sptr_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]                     cfg_data,
  input  wire logic [2:0]                      op,
  input  wire logic [5:0]                      col,
  input  wire logic [5:0]                      row,
  input  wire logic [15:0]                     value,
  input  wire logic [1:0]                      side,
  input  wire sptr_pkg::cmd_t                  cmd,
  output sptr_pkg::stat_t                      stat,
  output logic [15:0]                          read_value,
  output logic [sptr_pkg::PEND_W-1:0]          pending_count
);
  import sptr_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int NC = 2 ** AW;
  localparam int PW = (CW > RW) ? CW : RW;
  localparam int SW = PW + 2;
  localparam int NS = 2 ** SW;
  localparam logic [DIM_W-1:0] COLS_MAX = DIM_W'(MAX_COLS);
  localparam logic [DIM_W-1:0] ROWS_MAX = DIM_W'(MAX_ROWS);
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // configuration
  logic [6:0]  tile_cols;
  logic [6:0]  tile_rows;
  logic [15:0] org_x;
  logic [15:0] org_y;
  logic [15:0] grid_w;
  logic [15:0] grid_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_cols <= 7'd64;
      tile_rows <= 7'd64;
      org_x     <= 16'd0;
      org_y     <= 16'd0;
      grid_w    <= 16'd64;
      grid_h    <= 16'd64;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TILE_COLS:   tile_cols <= cfg_data[6:0];
        REG_TILE_ROWS:   tile_rows <= cfg_data[6:0];
        REG_ORIGIN_X:    org_x     <= cfg_data;
        REG_ORIGIN_Y:    org_y     <= cfg_data;
        REG_GRID_WIDTH:  grid_w    <= cfg_data;
        REG_GRID_HEIGHT: grid_h    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic [DIM_W-1:0] cols;
  logic [DIM_W-1:0] rows;

  always_comb begin
    if (tile_cols == 7'd0) begin
      cols = DIM_W'(1);
    end else if (DIM_W'(tile_cols) > COLS_MAX) begin
      cols = COLS_MAX;
    end else begin
      cols = DIM_W'(tile_cols);
    end
    if (tile_rows == 7'd0) begin
      rows = DIM_W'(1);
    end else if (DIM_W'(tile_rows) > ROWS_MAX) begin
      rows = ROWS_MAX;
    end else begin
      rows = DIM_W'(tile_rows);
    end
  end

  // held transaction
  logic [2:0]  it_op;
  logic [5:0]  it_col;
  logic [5:0]  it_row;
  logic [15:0] it_value;
  logic [1:0]  it_side;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_op    <= op;
      it_col   <= col;
      it_row   <= row;
      it_value <= value;
      it_side  <= side;
    end
  end

  logic          col_ok;
  logic          row_ok;
  logic          spill_ok;
  logic          tb_side;
  logic [AW-1:0] it_addr;
  logic [SW-1:0] it_saddr;

  assign col_ok   = DIM_W'(it_col) < cols;
  assign row_ok   = DIM_W'(it_row) < rows;
  assign tb_side  = (it_side == SIDE_TOP) || (it_side == SIDE_BOTTOM);
  assign spill_ok = tb_side ? col_ok : row_ok;
  assign it_addr  = {RW'(it_row), CW'(it_col)};
  assign it_saddr = {it_side, tb_side ? PW'(it_col) : PW'(it_row)};

  // scan position
  logic [CW-1:0] scan_x;
  logic [RW-1:0] scan_y;
  logic          scan_eol;
  logic          scan_last;

  assign scan_eol  = (DIM_W'(scan_x) + DIM_W'(1)) == cols;
  assign scan_last = scan_eol && ((DIM_W'(scan_y) + DIM_W'(1)) == rows);

  always_ff @(posedge clk) begin
    if (cmd.relax_init) begin
      scan_x <= '0;
      scan_y <= '0;
    end else if (cmd.scan_step) begin
      if (scan_eol) begin
        scan_x <= '0;
        scan_y <= scan_y + RW'(1);
      end else begin
        scan_x <= scan_x + CW'(1);
      end
    end
  end

  // toppling cell, grain count, global position
  logic [CW-1:0] cur_x;
  logic [RW-1:0] cur_y;
  logic [13:0]   k;
  logic [16:0]   sx;
  logic [16:0]   sy;
  logic [1:0]    nb;
  logic [AW-1:0] tgt_cell;
  logic [SW-1:0] tgt_spill;
  logic [AW-1:0] fifo_rdata;

  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      cur_x <= fifo_rdata[CW-1:0];
      cur_y <= fifo_rdata[AW-1:CW];
    end
  end

  // cell store
  logic [15:0]   cells [NC];
  logic [15:0]   cell_rdata;
  logic [AW-1:0] cell_raddr;
  logic [AW-1:0] cell_waddr;
  logic [15:0]   cell_wdata;
  logic [15:0]   give_sum;

  assign give_sum = sat_add16(cell_rdata, {2'b00, k});

  always_comb begin
    unique case (cmd.cell_rsel)
      ADDR_ITEM: cell_raddr = it_addr;
      ADDR_SCAN: cell_raddr = {scan_y, scan_x};
      ADDR_CUR:  cell_raddr = {cur_y, cur_x};
      default:   cell_raddr = tgt_cell;
    endcase
    unique case (cmd.cell_wsel)
      WR_SET: begin
        cell_waddr = it_addr;
        cell_wdata = it_value;
      end
      WR_ADD: begin
        cell_waddr = it_addr;
        cell_wdata = sat_add16(cell_rdata, it_value);
      end
      WR_REM: begin
        cell_waddr = {cur_y, cur_x};
        cell_wdata = {14'd0, cell_rdata[1:0]};
      end
      default: begin
        cell_waddr = tgt_cell;
        cell_wdata = give_sum;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_rd) begin
      cell_rdata <= cells[cell_raddr];
    end
    if (cmd.cell_wr) begin
      cells[cell_waddr] <= cell_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.topple_load) begin
      k  <= cell_rdata[15:2];
      sx <= {1'b0, org_x} + 17'(cur_x);
      sy <= {1'b0, org_y} + 17'(cur_y);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nb_clear) begin
      nb <= DIR_LEFT;
    end else if (cmd.nb_step) begin
      nb <= nb + 2'd1;
    end
  end

  // neighbour of the toppling cell
  logic [16:0]   gw17;
  logic [16:0]   gh17;
  logic          sx_in;
  logic          sy_in;
  logic          sx_dec_in;
  logic          sy_dec_in;
  logic          sx_inc_in;
  logic          sy_inc_in;
  logic          x_lo;
  logic          x_hi;
  logic          y_lo;
  logic          y_hi;
  logic          on_grid;
  logic          to_spill;
  logic [AW-1:0] nb_cell;
  logic [SW-1:0] nb_spill;
  logic [1:0]    nb_kind;

  assign gw17      = {1'b0, grid_w};
  assign gh17      = {1'b0, grid_h};
  assign sx_in     = sx < gw17;
  assign sy_in     = sy < gh17;
  assign sx_dec_in = (sx != 17'd0) && ((sx - 17'd1) < gw17);
  assign sy_dec_in = (sy != 17'd0) && ((sy - 17'd1) < gh17);
  assign sx_inc_in = (sx + 17'd1) < gw17;
  assign sy_inc_in = (sy + 17'd1) < gh17;
  assign x_lo      = cur_x == '0;
  assign y_lo      = cur_y == '0;
  assign x_hi      = (DIM_W'(cur_x) + DIM_W'(1)) == cols;
  assign y_hi      = (DIM_W'(cur_y) + DIM_W'(1)) == rows;

  always_comb begin
    unique case (nb)
      DIR_LEFT: begin
        on_grid  = sx_dec_in && sy_in;
        to_spill = x_lo;
        nb_spill = {SIDE_LEFT, PW'(cur_y)};
        nb_cell  = {cur_y, cur_x - CW'(1)};
      end
      DIR_DOWN: begin
        on_grid  = sx_in && sy_inc_in;
        to_spill = y_hi;
        nb_spill = {SIDE_BOTTOM, PW'(cur_x)};
        nb_cell  = {cur_y + RW'(1), cur_x};
      end
      DIR_RIGHT: begin
        on_grid  = sx_inc_in && sy_in;
        to_spill = x_hi;
        nb_spill = {SIDE_RIGHT, PW'(cur_y)};
        nb_cell  = {cur_y, cur_x + CW'(1)};
      end
      default: begin
        on_grid  = sx_in && sy_dec_in;
        to_spill = y_lo;
        nb_spill = {SIDE_TOP, PW'(cur_x)};
        nb_cell  = {cur_y - RW'(1), cur_x};
      end
    endcase
    if (!on_grid) begin
      nb_kind = KIND_LOST;
    end else if (to_spill) begin
      nb_kind = KIND_SPILL;
    end else begin
      nb_kind = KIND_CELL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tgt_load) begin
      tgt_cell  <= nb_cell;
      tgt_spill <= nb_spill;
    end
  end

  // queued flags: scan writes whether hot, a push sets, a pop clears
  logic          q_mem [NC];
  logic          q_rdata;
  logic [AW-1:0] q_waddr;
  logic          q_wdata;

  always_comb begin
    unique case (cmd.q_wsel)
      ADDR_SCAN: begin
        q_waddr = {scan_y, scan_x};
        q_wdata = |cell_rdata[15:2];
      end
      ADDR_CUR: begin
        q_waddr = {cur_y, cur_x};
        q_wdata = 1'b0;
      end
      default: begin
        q_waddr = tgt_cell;
        q_wdata = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.q_rd) begin
      q_rdata <= q_mem[tgt_cell];
    end
    if (cmd.q_wr) begin
      q_mem[q_waddr] <= q_wdata;
    end
  end

  // work list
  logic [AW-1:0] fifo [NC];
  logic [AW-1:0] head;
  logic [AW:0]   count;

  always_ff @(posedge clk) begin
    if (cmd.fifo_push) begin
      fifo[head + count[AW-1:0]] <= cmd.push_tgt ? tgt_cell : {scan_y, scan_x};
    end
    if (cmd.fifo_pop) begin
      fifo_rdata <= fifo[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.relax_init) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.fifo_push) begin
      count <= count + (AW+1)'(1);
    end else if (cmd.fifo_pop) begin
      head  <= head + AW'(1);
      count <= count - (AW+1)'(1);
    end
  end

  // spill counters, entry not valid reads as zero
  logic [15:0]      spill [NS];
  logic [NS-1:0]    spill_vld;
  logic [15:0]      spill_rdata;
  logic             spill_rvalid;
  logic [SW-1:0]    spill_raddr;
  logic [15:0]      spill_sum;
  logic [CNT_W-1:0] nz_cnt;
  logic [PEND_W-1:0] pending;

  assign spill_raddr = cmd.spill_rtgt ? tgt_spill : it_saddr;
  assign spill_sum   = sat_add16(spill_rvalid ? spill_rdata : 16'd0, {2'b00, k});

  always_ff @(posedge clk) begin
    if (cmd.spill_rd) begin
      spill_rdata  <= spill[spill_raddr];
      spill_rvalid <= spill_vld[spill_raddr];
    end
    if (cmd.spill_wr) begin
      spill[tgt_spill] <= spill_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.relax_init) begin
      spill_vld <= '0;
      nz_cnt    <= '0;
    end else if (cmd.spill_wr) begin
      spill_vld[tgt_spill] <= 1'b1;
      if (!spill_rvalid) begin
        nz_cnt <= nz_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (cmd.pend_load) begin
      pending <= (nz_cnt > CNT_W'(511)) ? PEND_W'(511) : nz_cnt[PEND_W-1:0];
    end
  end

  // result
  logic [15:0] res_value;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_CELL:  res_value <= cell_rdata;
        RES_SPILL: res_value <= (spill_ok && spill_rvalid) ? spill_rdata : 16'd0;
        default:   res_value <= 16'd0;
      endcase
    end
    if (cmd.out_load) begin
      read_value    <= res_value;
      pending_count <= pending;
    end
  end

  assign stat.op         = it_op;
  assign stat.in_tile    = col_ok && row_ok;
  assign stat.hot        = |cell_rdata[15:2];
  assign stat.scan_last  = scan_last;
  assign stat.fifo_empty = count == '0;
  assign stat.kind       = nb_kind;
  assign stat.nb_last    = nb == DIR_UP;
  assign stat.give_hot   = |give_sum[15:2];
  assign stat.queued     = q_rdata;

endmodule
`default_nettype wire

### rtl/sandpile_tile_relaxer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sandpile_tile_relaxer: one tile of an abelian sandpile
// write, add, read cells and spill counters; relax topples the whole tile
// ----------------------------------------------------------------------------
// latency from accept to result valid depends on the op; a relax scans every
//   in-tile cell, then pops the work list and serves each neighbour of a topple
// one transaction in flight, the next accepted once it has finished; one is taken while a result waits
// the scan and topple loop run through single-port cell and work-list memories
// reset: registers to 64, 64, 0, 0, 64, 64, spill counters and pending count
//   to zero, work list empty; cells are undefined until written, no clear pass
module sandpile_tile_relaxer #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration writes
  input  wire logic                            cfg_write,
  input  wire logic [sptr_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]                     cfg_data,
  // input transaction
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [2:0]                      op,
  input  wire logic [5:0]                      col,
  input  wire logic [5:0]                      row,
  input  wire logic [15:0]                     value,
  input  wire logic [1:0]                      side,
  // result transaction
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [15:0]                          read_value,
  output logic [sptr_pkg::PEND_W-1:0]          pending_count
);
  import sptr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: one state per memory access step
  sptr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and arithmetic: cells, work list, spill counters, result registers
  sptr_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .col           (col),
    .row           (row),
    .value         (value),
    .side          (side),
    .cmd           (cmd),
    .stat          (stat),
    .read_value    (read_value),
    .pending_count (pending_count)
  );

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the sandpile tile relaxer
// a queue-fed driver and a clocked monitor check every result against an
// in-bench prediction of the tile, over several tile shapes and grid positions
// ----------------------------------------------------------------------------
module tb_top;
  import sptr_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [15:0] value;
    logic [1:0]  side;
  } grain_cmd_t;

  typedef struct {
    logic [15:0] rd;
    logic [8:0]  pend;
  } tile_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] op = '0;
  logic [5:0] col = '0;
  logic [5:0] row = '0;
  logic [15:0] value = '0;
  logic [1:0] side = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] read_value;
  logic [PEND_W-1:0] pending_count;

  sandpile_tile_relaxer dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .col(col), .row(row), .value(value), .side(side),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .pending_count(pending_count)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- tile copy
  logic [15:0] pile[4096];
  bit          written[4096];
  bit          in_queue[4096];
  int          topple_q[$];
  logic [15:0] edge_top[64], edge_bottom[64], edge_left[64], edge_right[64];
  logic [8:0]  pend_total = '0;
  int          t_cols = 64, t_rows = 64, org_x = 0, org_y = 0, grid_w = 64, grid_h = 64;

  grain_cmd_t  cmd_q[$];     // transactions waiting for the driver
  tile_resp_t  resp_q[$];    // predicted results, oldest first
  grain_cmd_t  drv_cmd;
  logic        in_fire = 1'b0;
  bit          calm = 0;     // no idling on either side while set
  int          errors = 0;
  int          n_items = 0, n_relax = 0, n_results = 0;

  function automatic int clamp_dim(int v);
    if (v < 1) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic logic [15:0] add_sat(logic [15:0] a, int b);
    int s;
    s = a + b;
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void queue_cell(int idx);
    if (!in_queue[idx]) begin
      in_queue[idx] = 1;
      topple_q = {topple_q, idx};
    end
  endfunction

  // one neighbour share of a topple: cell, side counter or the sink
  function automatic void pass_grains(int x, int y, int k, int cols, int rows);
    longint gx, gy;
    int idx;
    gx = org_x + x;
    gy = org_y + y;
    if (gx < 0 || gx >= grid_w || gy < 0 || gy >= grid_h) return;
    if (y < 0) edge_top[x] = add_sat(edge_top[x], k);
    else if (y >= rows) edge_bottom[x] = add_sat(edge_bottom[x], k);
    else if (x < 0) edge_left[y] = add_sat(edge_left[y], k);
    else if (x >= cols) edge_right[y] = add_sat(edge_right[y], k);
    else begin
      idx = y * 64 + x;
      pile[idx] = add_sat(pile[idx], k);
      if (pile[idx] >= 4) queue_cell(idx);
    end
  endfunction

  function automatic void relax_pile();
    int cols, rows, idx, k, x, y, n;
    cols = clamp_dim(t_cols);
    rows = clamp_dim(t_rows);
    for (int i = 0; i < 64; i++) begin
      edge_top[i] = 0; edge_bottom[i] = 0; edge_left[i] = 0; edge_right[i] = 0;
    end
    for (int i = 0; i < 4096; i++) in_queue[i] = 0;
    topple_q.delete();
    for (int yy = 0; yy < rows; yy++)
      for (int xx = 0; xx < cols; xx++)
        if (pile[yy * 64 + xx] >= 4) queue_cell(yy * 64 + xx);
    while (topple_q.size() > 0) begin
      idx = topple_q.pop_front();
      in_queue[idx] = 0;
      k = pile[idx] / 4;
      if (k == 0) continue;
      pile[idx] = pile[idx] - 4 * k;
      x = idx % 64;
      y = idx / 64;
      pass_grains(x - 1, y, k, cols, rows);
      pass_grains(x, y + 1, k, cols, rows);
      pass_grains(x + 1, y, k, cols, rows);
      pass_grains(x, y - 1, k, cols, rows);
    end
    n = 0;
    for (int i = 0; i < cols; i++) begin
      if (edge_top[i] != 0) n++;
      if (edge_bottom[i] != 0) n++;
    end
    for (int i = 0; i < rows; i++) begin
      if (edge_left[i] != 0) n++;
      if (edge_right[i] != 0) n++;
    end
    pend_total = (n > 511) ? 9'd511 : n[8:0];
  endfunction

  function automatic tile_resp_t apply_cmd(grain_cmd_t c);
    tile_resp_t r;
    int cols, rows, idx;
    bit hit;
    cols = clamp_dim(t_cols);
    rows = clamp_dim(t_rows);
    hit = (c.col < cols) && (c.row < rows);
    idx = c.row * 64 + c.col;
    r.rd = '0;
    case (c.op)
      OP_WRITE: if (hit) pile[idx] = c.value;
      OP_ADD:   if (hit) pile[idx] = add_sat(pile[idx], c.value);
      OP_RELAX: relax_pile();
      OP_READ:  if (hit) r.rd = pile[idx];
      OP_SPILL: begin
        if (c.side == SIDE_TOP && c.col < cols) r.rd = edge_top[c.col];
        else if (c.side == SIDE_RIGHT && c.row < rows) r.rd = edge_right[c.row];
        else if (c.side == SIDE_BOTTOM && c.col < cols) r.rd = edge_bottom[c.col];
        else if (c.side == SIDE_LEFT && c.row < rows) r.rd = edge_left[c.row];
      end
      default: ;
    endcase
    r.pend = pend_total;
    return r;
  endfunction

  // ------------------------------------------------------------ driver side
  always @(posedge clk) begin
    grain_cmd_t seen;
    in_fire <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      seen.op = op; seen.col = col; seen.row = row;
      seen.value = value; seen.side = side;
      resp_q = {resp_q, apply_cmd(seen)};
    end
  end

  // next transaction at the falling edge once the held one has gone
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (cmd_q.size() > 0 && (calm || $urandom_range(0, 99) >= 8)) begin
        drv_cmd = cmd_q.pop_front();
        op <= drv_cmd.op; col <= drv_cmd.col; row <= drv_cmd.row;
        value <= drv_cmd.value; side <= drv_cmd.side;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------- monitor side
  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(0, 99) < 8);
  end

  always @(posedge clk) begin
    tile_resp_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (resp_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        e = resp_q.pop_front();
        if (read_value !== e.rd) begin
          $error("read_value expected %0d actual %0d", e.rd, read_value);
          errors++;
        end
        if (pending_count !== e.pend) begin
          $error("pending_count expected %0d actual %0d", e.pend, pending_count);
          errors++;
        end
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic set_reg(logic [REG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[15:0];
    case (idx)
      REG_TILE_COLS:   t_cols = data & 8'h7F;
      REG_TILE_ROWS:   t_rows = data & 8'h7F;
      REG_ORIGIN_X:    org_x  = data & 16'hFFFF;
      REG_ORIGIN_Y:    org_y  = data & 16'hFFFF;
      REG_GRID_WIDTH:  grid_w = data & 16'hFFFF;
      REG_GRID_HEIGHT: grid_h = data & 16'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_cmd(logic [2:0] o, int c, int r, int v, logic [1:0] s);
    grain_cmd_t g;
    int cols, rows;
    cols = clamp_dim(t_cols);
    rows = clamp_dim(t_rows);
    // never touch a cell that has not been written
    if ((o == OP_ADD || o == OP_READ) && c < cols && r < rows && !written[r * 64 + c])
      o = OP_WRITE;
    if (o == OP_WRITE && c < cols && r < rows) written[r * 64 + c] = 1;
    g.op = o; g.col = c[5:0]; g.row = r[5:0]; g.value = v[15:0]; g.side = s;
    cmd_q = {cmd_q, g};
    n_items++;
    if (o == OP_RELAX) n_relax++;
  endtask

  function automatic int grain_value();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return $urandom_range(0, 7);
    if (p < 90) return $urandom & 16'hFFFF;
    return $urandom_range(65530, 65535);
  endfunction

  task automatic drain();
    wait (cmd_q.size() == 0 && !in_valid && resp_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic run_phase(int c, int r, int ox, int oy, int gw, int gh,
                           int n_rand, bit directed);
    int cols, rows, p, cc, rr;
    logic [2:0] o;
    drain();
    set_reg(REG_TILE_COLS, c);
    set_reg(REG_TILE_ROWS, r);
    set_reg(REG_ORIGIN_X, ox);
    set_reg(REG_ORIGIN_Y, oy);
    set_reg(REG_GRID_WIDTH, gw);
    set_reg(REG_GRID_HEIGHT, gh);
    cols = clamp_dim(t_cols);
    rows = clamp_dim(t_rows);
    // fill the tile in use so that every relax sees written cells only
    for (int y = 0; y < rows; y++)
      for (int x = 0; x < cols; x++)
        push_cmd(OP_WRITE, x, y, grain_value(), 2'($urandom));
    if (directed) begin
      push_cmd(OP_WRITE, 0, 0, 65535, SIDE_TOP);
      push_cmd(OP_ADD, 0, 0, 65535, SIDE_TOP);     // saturation of a cell
      push_cmd(OP_READ, 0, 0, 0, SIDE_TOP);
      push_cmd(OP_WRITE, 63, 63, 12, SIDE_LEFT);   // outside the tile: ignored
      push_cmd(OP_ADD, 40, 2, 9, SIDE_LEFT);
      push_cmd(OP_READ, 63, 63, 0, SIDE_LEFT);
      push_cmd(OP_RELAX, 0, 0, 0, SIDE_TOP);
      for (int s = 0; s < 4; s++) begin
        push_cmd(OP_SPILL, 1, 2, 0, s[1:0]);
        push_cmd(OP_SPILL, 63, 63, 0, s[1:0]);     // index past the tile
      end
      push_cmd(3'd5, 1, 1, 65535, 2'd3);           // undefined ops
      push_cmd(3'd6, 0, 0, 0, 2'd0);
      push_cmd(3'd7, 63, 63, 65535, 2'd3);
      push_cmd(OP_READ, 1, 1, 0, SIDE_TOP);
      push_cmd(OP_RELAX, 0, 0, 0, SIDE_TOP);
      push_cmd(OP_READ, cols - 1, rows - 1, 0, SIDE_TOP);
    end
    for (int i = 0; i < n_rand; i++) begin
      p = $urandom_range(0, 99);
      if (p < 15) o = OP_WRITE;
      else if (p < 40) o = OP_ADD;
      else if (p < 52) o = OP_RELAX;
      else if (p < 75) o = OP_READ;
      else if (p < 93) o = OP_SPILL;
      else o = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 99) < 80) begin
        cc = $urandom_range(0, cols - 1);
        rr = $urandom_range(0, rows - 1);
      end else begin
        cc = $urandom_range(0, 63);
        rr = $urandom_range(0, 63);
      end
      push_cmd(o, cc, rr, grain_value(), 2'($urandom));
    end
    push_cmd(OP_RELAX, 0, 0, 0, SIDE_TOP);
    for (int s = 0; s < 4; s++)
      push_cmd(OP_SPILL, $urandom_range(0, cols - 1), $urandom_range(0, rows - 1), 0, s[1:0]);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // corner tile: top and left grains fall off the grid
    run_phase(4, 4, 0, 0, 64, 64, 30, 1);
    // interior tile: every side spills
    run_phase(8, 6, 10, 10, 100, 100, 35, 0);
    // zero size acts as one cell, which itself sits off the grid
    run_phase(0, 0, 65535, 65535, 65535, 65535, 15, 0);
    run_phase(64, 1, 0, 5, 64, 65535, 35, 0);
    // oversize acts as the maximum
    run_phase(127, 2, 7, 0, 65535, 1, 30, 0);
    run_phase(1, 64, 3, 0, 4, 64, 30, 0);
    run_phase(5, 5, 2, 2, 7, 7, 35, 0);
    calm = 1;
    run_phase(8, 8, 1000, 1000, 65535, 65535, 40, 0);
    calm = 0;
    run_phase(3, 3, 0, 0, 1, 1, 30, 0);
    drain();
    $display("covered %0d transactions, %0d relaxes, %0d results, nine tile settings",
             n_items, n_relax, n_results);
    $display("shapes from one cell up to full width and full height, corner, interior and off-grid tiles");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
